// ----- hdl/fbdc_pkg.sv -----
// Shared widths, reset values, register indexes, opcodes and the box status bundle.
package fbdc_pkg;

  localparam int SIZE_W    = 11;
  localparam int MARGIN_W  = 6;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;
  localparam int COLOR_W   = 8;
  localparam int DEPTH_W   = 32;
  localparam int COORD_W   = 10;

  localparam logic [SIZE_W-1:0]   FRAME_WIDTH_RST  = SIZE_W'(512);
  localparam logic [SIZE_W-1:0]   FRAME_HEIGHT_RST = SIZE_W'(424);
  localparam logic [MARGIN_W-1:0] MARGIN_RST       = MARGIN_W'(4);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_MARGIN       = 2'd2
  } cfg_index_t;

  typedef enum logic {
    OP_DETECT    = 1'b0,
    OP_COMPOSITE = 1'b1
  } op_t;

  typedef struct packed {
    logic [COORD_W-1:0] top;
    logic [COORD_W-1:0] bottom;
    logic [COORD_W-1:0] left;
    logic [COORD_W-1:0] right;
    logic               found;
    logic               in_box;
  } box_status_t;

endpackage

// ----- hdl/fbdc_raster.sv -----
// Raster position counter for one pass, with end-of-frame flag.
module fbdc_raster #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  localparam int COL_W = $clog2(MAX_WIDTH),
  localparam int ROW_W = $clog2(MAX_HEIGHT)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step,
  input  logic [fbdc_pkg::SIZE_W-1:0] frame_width,
  input  logic [fbdc_pkg::SIZE_W-1:0] frame_height,
  output logic [COL_W-1:0]            col,
  output logic [ROW_W-1:0]            row,
  output logic                        last
);
  import fbdc_pkg::*;

  localparam int CSZ_W = (SIZE_W > COL_W + 1) ? SIZE_W : COL_W + 1;
  localparam int RSZ_W = (SIZE_W > ROW_W + 1) ? SIZE_W : ROW_W + 1;

  logic [CSZ_W-1:0] w_ext, w_eff, col_inc;
  logic [RSZ_W-1:0] h_ext, h_eff, row_inc;
  logic             col_wrap, row_wrap;

  // Clamp frame size to 1..MAX
  always_comb begin
    w_ext = CSZ_W'(frame_width);
    h_ext = RSZ_W'(frame_height);
    if (w_ext == '0) begin
      w_eff = CSZ_W'(1);
    end else if (w_ext > CSZ_W'(MAX_WIDTH)) begin
      w_eff = CSZ_W'(MAX_WIDTH);
    end else begin
      w_eff = w_ext;
    end
    if (h_ext == '0) begin
      h_eff = RSZ_W'(1);
    end else if (h_ext > RSZ_W'(MAX_HEIGHT)) begin
      h_eff = RSZ_W'(MAX_HEIGHT);
    end else begin
      h_eff = h_ext;
    end
  end

  // Wrap at or beyond the last column / row
  assign col_inc  = CSZ_W'(col) + CSZ_W'(1);
  assign row_inc  = RSZ_W'(row) + RSZ_W'(1);
  assign col_wrap = col_inc >= w_eff;
  assign row_wrap = row_inc >= h_eff;
  assign last     = col_wrap && row_wrap;

  // Advance position on each transfer of this pass
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (step) begin
      if (col_wrap) begin
        col <= '0;
        row <= row_wrap ? '0 : ROW_W'(row_inc);
      end else begin
        col <= COL_W'(col_inc);
      end
    end
  end

endmodule

// ----- hdl/fbdc_box.sv -----
// Foreground bounding box tracker and widened-box membership test.
module fbdc_box #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  localparam int COL_W = $clog2(MAX_WIDTH),
  localparam int ROW_W = $clog2(MAX_HEIGHT)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          detect_step,
  input  logic                          fg,
  input  logic [COL_W-1:0]              det_col,
  input  logic [ROW_W-1:0]              det_row,
  input  logic [COL_W-1:0]              comp_col,
  input  logic [ROW_W-1:0]              comp_row,
  input  logic [fbdc_pkg::MARGIN_W-1:0] margin,
  output fbdc_pkg::box_status_t         status
);
  import fbdc_pkg::*;

  localparam int CCMP_W = ((COL_W > MARGIN_W) ? COL_W : MARGIN_W) + 1;
  localparam int RCMP_W = ((ROW_W > MARGIN_W) ? ROW_W : MARGIN_W) + 1;

  logic [ROW_W-1:0] top_row, bottom_row, top_row_next, bottom_row_next;
  logic [COL_W-1:0] left_col, right_col, left_col_next, right_col_next;
  logic             found_flag, found_flag_next;
  logic             first_pixel;

  assign first_pixel = (det_row == '0) && (det_col == '0);

  // Clear at frame start, then seed or grow the box
  always_comb begin
    top_row_next    = top_row;
    bottom_row_next = bottom_row;
    left_col_next   = left_col;
    right_col_next  = right_col;
    found_flag_next = found_flag;
    if (detect_step) begin
      if (first_pixel) begin
        top_row_next    = '0;
        bottom_row_next = '0;
        left_col_next   = '0;
        right_col_next  = '0;
        found_flag_next = 1'b0;
      end
      if (fg) begin
        if (!found_flag_next) begin
          top_row_next    = det_row;
          bottom_row_next = det_row;
          left_col_next   = det_col;
          right_col_next  = det_col;
          found_flag_next = 1'b1;
        end else begin
          if (det_row < top_row_next)    top_row_next    = det_row;
          if (det_row > bottom_row_next) bottom_row_next = det_row;
          if (det_col < left_col_next)   left_col_next   = det_col;
          if (det_col > right_col_next)  right_col_next  = det_col;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      top_row    <= '0;
      bottom_row <= '0;
      left_col   <= '0;
      right_col  <= '0;
      found_flag <= 1'b0;
    end else begin
      top_row    <= top_row_next;
      bottom_row <= bottom_row_next;
      left_col   <= left_col_next;
      right_col  <= right_col_next;
      found_flag <= found_flag_next;
    end
  end

  // Report the box after this pixel's update, masked to output width
  assign status.top    = COORD_W'(top_row_next);
  assign status.bottom = COORD_W'(bottom_row_next);
  assign status.left   = COORD_W'(left_col_next);
  assign status.right  = COORD_W'(right_col_next);
  assign status.found  = found_flag_next;

  // Widened box test without wrap below zero
  assign status.in_box = found_flag &&
      (RCMP_W'(comp_row) + RCMP_W'(margin) >= RCMP_W'(top_row)) &&
      (RCMP_W'(comp_row) <= RCMP_W'(bottom_row) + RCMP_W'(margin)) &&
      (CCMP_W'(comp_col) + CCMP_W'(margin) >= CCMP_W'(left_col)) &&
      (CCMP_W'(comp_col) <= CCMP_W'(right_col) + CCMP_W'(margin));

  a_box_ordered: assert property (@(posedge clk) disable iff (rst)
    found_flag |-> (top_row <= bottom_row) && (left_col <= right_col))
    else $error("box corners out of order");

endmodule

// ----- hdl/foreground_box_depth_composite_top.sv -----
// An input transfer loads the input register; it moves into the result register once
// the result register is empty or being taken, and is then offered as a result.
// Throughput: one pixel per clock while out_stall is low; box and raster updates never hold the flow.
// An input register and a result register decouple the two channels.
// Reset clears pass positions, the box and the found flag, and restores
// frame_width 512, frame_height 424, margin 4.
module foreground_box_depth_composite_top #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [fbdc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fbdc_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           operation,
  input  logic [fbdc_pkg::COLOR_W-1:0]   back_red,
  input  logic [fbdc_pkg::COLOR_W-1:0]   back_green,
  input  logic [fbdc_pkg::COLOR_W-1:0]   back_blue,
  input  logic [fbdc_pkg::COLOR_W-1:0]   proc_red,
  input  logic [fbdc_pkg::COLOR_W-1:0]   proc_green,
  input  logic [fbdc_pkg::COLOR_W-1:0]   proc_blue,
  input  logic [fbdc_pkg::DEPTH_W-1:0]   live_depth,
  input  logic [fbdc_pkg::DEPTH_W-1:0]   back_depth,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [fbdc_pkg::DEPTH_W-1:0]   out_depth,
  output logic [fbdc_pkg::COORD_W-1:0]   box_top,
  output logic [fbdc_pkg::COORD_W-1:0]   box_bottom,
  output logic [fbdc_pkg::COORD_W-1:0]   box_left,
  output logic [fbdc_pkg::COORD_W-1:0]   box_right,
  output logic                           box_found,
  output logic                           frame_end
);
  import fbdc_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);

  logic [SIZE_W-1:0]   frame_width, frame_height;
  logic [MARGIN_W-1:0] margin;

  logic               in_full, in_op, in_fg;
  logic [DEPTH_W-1:0] in_live, in_back;
  logic               advance, take, det_step, comp_step;

  logic [COL_W-1:0] det_col, comp_col;
  logic [ROW_W-1:0] det_row, comp_row;
  logic             det_last, comp_last;
  box_status_t      box;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RST;
      frame_height <= FRAME_HEIGHT_RST;
      margin       <= MARGIN_RST;
    end else if (cfg_write) begin
      if (cfg_index == CFG_FRAME_WIDTH)  frame_width  <= SIZE_W'(cfg_data);
      if (cfg_index == CFG_FRAME_HEIGHT) frame_height <= SIZE_W'(cfg_data);
      if (cfg_index == CFG_MARGIN)       margin       <= MARGIN_W'(cfg_data);
    end
  end

  // Handshake: move the input register into the result register
  assign advance   = in_full && (!out_valid || !out_stall);
  assign in_stall  = in_full && !advance;
  assign take      = in_valid && !in_stall;
  assign det_step  = advance && (in_op == OP_DETECT);
  assign comp_step = advance && (in_op == OP_COMPOSITE);

  // Input register; reduce the color compare to one foreground bit
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (take) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_op   <= operation;
      in_fg   <= (back_red != proc_red) && (back_green != proc_green) &&
                 (back_blue != proc_blue);
      in_live <= live_depth;
      in_back <= back_depth;
    end
  end

  fbdc_raster #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_det_raster (
    .clk          (clk),
    .rst          (rst),
    .step         (det_step),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .col          (det_col),
    .row          (det_row),
    .last         (det_last)
  );

  fbdc_raster #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_comp_raster (
    .clk          (clk),
    .rst          (rst),
    .step         (comp_step),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .col          (comp_col),
    .row          (comp_row),
    .last         (comp_last)
  );

  fbdc_box #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_box (
    .clk         (clk),
    .rst         (rst),
    .detect_step (det_step),
    .fg          (in_fg),
    .det_col     (det_col),
    .det_row     (det_row),
    .comp_col    (comp_col),
    .comp_row    (comp_row),
    .margin      (margin),
    .status      (box)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (in_op == OP_COMPOSITE) begin
        out_depth <= box.in_box ? in_live : in_back;
        frame_end <= comp_last;
      end else begin
        out_depth <= '0;
        frame_end <= det_last;
      end
      box_top    <= box.top;
      box_bottom <= box.bottom;
      box_left   <= box.left;
      box_right  <= box.right;
      box_found  <= box.found;
    end
  end

  a_detect_zero_depth: assert property (@(posedge clk) disable iff (rst)
    det_step |=> out_depth == '0)
    else $error("detect pixel produced nonzero depth");

  a_no_box_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !box_found |-> box_top == '0 && box_bottom == '0 &&
                                box_left == '0 && box_right == '0)
    else $error("box coordinates set without foreground");

  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    in_full && !advance |=> in_full && $stable(in_live) && $stable(in_op))
    else $error("held input register lost its pixel");

endmodule

// ----- dv/foreground_box_depth_composite_top_tb.sv -----
`timescale 1ns / 100ps
// Self-checking bench for the foreground box tracker and depth compositor, with a local predictor.
module foreground_box_depth_composite_top_tb;
  import fbdc_pkg::*;

  localparam int MAX_W          = 1024;
  localparam int MAX_H          = 1024;
  localparam int LATENCY        = 2;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_PIXELS  = 1000;

  typedef struct {
    op_t                op;
    logic [COLOR_W-1:0] bg_r, bg_g, bg_b, pr_r, pr_g, pr_b;
    logic [DEPTH_W-1:0] live, bgd;
  } pixel_t;

  typedef struct {
    logic [DEPTH_W-1:0] depth;
    logic [COORD_W-1:0] top, bottom, left, right;
    logic               found, last;
  } pixel_result_t;

  // DUT signals
  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 operation = 1'b0;
  logic [COLOR_W-1:0]   back_red = '0, back_green = '0, back_blue = '0;
  logic [COLOR_W-1:0]   proc_red = '0, proc_green = '0, proc_blue = '0;
  logic [DEPTH_W-1:0]   live_depth = '0, back_depth = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [DEPTH_W-1:0]   out_depth;
  logic [COORD_W-1:0]   box_top, box_bottom, box_left, box_right;
  logic                 box_found, frame_end;

  // Predictor state and register shadows
  int unsigned          det_col, det_row, cmp_col, cmp_row;
  logic [COORD_W-1:0]   fg_top = '0, fg_bottom = '0, fg_left = '0, fg_right = '0;
  bit                   fg_seen;
  logic [SIZE_W-1:0]    shadow_width;
  logic [SIZE_W-1:0]    shadow_height;
  logic [MARGIN_W-1:0]  shadow_margin;

  pixel_t               pending_px[$];
  pixel_result_t        expected_px[$];
  pixel_t               cur_px;
  pixel_result_t        want_px;
  bit                   in_taken = 1'b0;
  int                   send_idle_pct = 0;
  int                   recv_stall_pct = 0;
  int                   errors = 0;
  int                   idle_cycles = 0;
  int                   random_count = 0;
  int                   phase_no = 0;

  foreground_box_depth_composite_top uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .operation  (operation),
    .back_red   (back_red),
    .back_green (back_green),
    .back_blue  (back_blue),
    .proc_red   (proc_red),
    .proc_green (proc_green),
    .proc_blue  (proc_blue),
    .live_depth (live_depth),
    .back_depth (back_depth),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_depth  (out_depth),
    .box_top    (box_top),
    .box_bottom (box_bottom),
    .box_left   (box_left),
    .box_right  (box_right),
    .box_found  (box_found),
    .frame_end  (frame_end)
  );

  always #5 clk = ~clk;

  // Zero counts as one, oversize saturates
  function automatic int unsigned clamp_size(logic [SIZE_W-1:0] v, int unsigned lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return v;
  endfunction

  // Advance a raster position; flag the last pixel of the frame
  function automatic bit step_raster(inout int unsigned col, inout int unsigned row);
    int unsigned w, h;
    w = clamp_size(shadow_width, MAX_W);
    h = clamp_size(shadow_height, MAX_H);
    if (col + 1 >= w) begin
      col = 0;
      if (row + 1 >= h) begin
        row = 0;
        return 1'b1;
      end
      row++;
      return 1'b0;
    end
    col++;
    return 1'b0;
  endfunction

  // Update the box or composite one depth word, then report the current box
  function automatic pixel_result_t predict_pixel(pixel_t px);
    pixel_result_t res;
    int unsigned   r, c, m;
    bit            fg, near;
    res.depth = '0;
    if (px.op == OP_DETECT) begin
      r = det_row;
      c = det_col;
      fg = (px.bg_r != px.pr_r) && (px.bg_g != px.pr_g) && (px.bg_b != px.pr_b);
      if (r == 0 && c == 0) begin
        fg_seen = 1'b0;
        fg_top = '0;
        fg_bottom = '0;
        fg_left = '0;
        fg_right = '0;
      end
      if (fg) begin
        if (!fg_seen) begin
          fg_top = COORD_W'(r);
          fg_bottom = COORD_W'(r);
          fg_left = COORD_W'(c);
          fg_right = COORD_W'(c);
          fg_seen = 1'b1;
        end else begin
          if (r < fg_top) fg_top = COORD_W'(r);
          if (r > fg_bottom) fg_bottom = COORD_W'(r);
          if (c < fg_left) fg_left = COORD_W'(c);
          if (c > fg_right) fg_right = COORD_W'(c);
        end
      end
      res.last = step_raster(det_col, det_row);
    end else begin
      r = cmp_row;
      c = cmp_col;
      m = 32'(shadow_margin);
      near = fg_seen && (r + m >= fg_top) && (r <= fg_bottom + m) &&
             (c + m >= fg_left) && (c <= fg_right + m);
      res.depth = near ? px.live : px.bgd;
      res.last = step_raster(cmp_col, cmp_row);
    end
    res.top = fg_top;
    res.bottom = fg_bottom;
    res.left = fg_left;
    res.right = fg_right;
    res.found = fg_seen;
    return res;
  endfunction

  // Random pixel; without foreground at least one channel pair matches
  function automatic pixel_t make_pixel(op_t op, bit fg);
    pixel_t     px;
    logic [2:0] same;
    px.op = op;
    px.bg_r = COLOR_W'($urandom);
    px.bg_g = COLOR_W'($urandom);
    px.bg_b = COLOR_W'($urandom);
    px.pr_r = px.bg_r ^ COLOR_W'($urandom_range(1, 255));
    px.pr_g = px.bg_g ^ COLOR_W'($urandom_range(1, 255));
    px.pr_b = px.bg_b ^ COLOR_W'($urandom_range(1, 255));
    px.live = $urandom;
    px.bgd = $urandom;
    if (!fg) begin
      same = 3'($urandom_range(1, 7));
      if (same[0]) px.pr_r = px.bg_r;
      if (same[1]) px.pr_g = px.bg_g;
      if (same[2]) px.pr_b = px.bg_b;
    end
    return px;
  endfunction

  function automatic pixel_t fixed_pixel(op_t op, logic [7:0] br, logic [7:0] bgr,
                                         logic [7:0] bb, logic [7:0] pr, logic [7:0] pg,
                                         logic [7:0] pb, logic [31:0] live,
                                         logic [31:0] bgd);
    pixel_t px;
    px.op = op;
    px.bg_r = br;
    px.bg_g = bgr;
    px.bg_b = bb;
    px.pr_r = pr;
    px.pr_g = pg;
    px.pr_b = pb;
    px.live = live;
    px.bgd = bgd;
    return px;
  endfunction

  // Append one pixel to the driver's queue
  function automatic void queue_pixel(pixel_t px);
    pending_px = {pending_px, px};
  endfunction

  task automatic report_mismatch(string what, logic [DEPTH_W-1:0] got,
                                 logic [DEPTH_W-1:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic check_field(string what, logic [DEPTH_W-1:0] got, logic [DEPTH_W-1:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  task automatic write_reg(cfg_index_t idx, logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      CFG_FRAME_WIDTH:  shadow_width = value;
      CFG_FRAME_HEIGHT: shadow_height = value;
      CFG_MARGIN:       shadow_margin = value[MARGIN_W-1:0];
      default: ;
    endcase
  endtask

  // Drain every pending transfer and result, then let the pipeline settle
  task automatic wait_idle();
    while (pending_px.size() != 0 || in_valid || expected_px.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic set_idling(int mode);
    case (mode % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
      default: begin send_idle_pct = 11; recv_stall_pct = 11; end
    endcase
  endtask

  // One detect frame, usually with a blob of foreground, then one composite frame
  task automatic queue_frame_pair();
    int unsigned w, h, t, b, l, rt, r, c;
    bit          blank, fg;
    w = clamp_size(shadow_width, MAX_W);
    h = clamp_size(shadow_height, MAX_H);
    t = $urandom_range(h - 1);
    b = $urandom_range(h - 1, t);
    l = $urandom_range(w - 1);
    rt = $urandom_range(w - 1, l);
    blank = ($urandom_range(9) == 0);
    for (r = 0; r < h; r++) begin
      for (c = 0; c < w; c++) begin
        if (r >= t && r <= b && c >= l && c <= rt) fg = ($urandom_range(99) < 80);
        else fg = ($urandom_range(99) < 3);
        queue_pixel(make_pixel(OP_DETECT, fg && !blank));
        random_count++;
      end
    end
    for (r = 0; r < w * h; r++) begin
      queue_pixel(make_pixel(OP_COMPOSITE, 1'b0));
      random_count++;
    end
  endtask

  // Sender: hold a stalled transfer, otherwise pick the next pixel or idle
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      expected_px = {expected_px, predict_pixel(cur_px)};
      in_taken = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (!in_valid || in_taken) begin
      in_taken = 1'b0;
      if (!rst && pending_px.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        cur_px = pending_px.pop_front();
        operation <= cur_px.op;
        back_red <= cur_px.bg_r;
        back_green <= cur_px.bg_g;
        back_blue <= cur_px.bg_b;
        proc_red <= cur_px.pr_r;
        proc_green <= cur_px.pr_g;
        proc_blue <= cur_px.pr_b;
        live_depth <= cur_px.live;
        back_depth <= cur_px.bgd;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_px.size() == 0) begin
        report_mismatch("unexpected result, depth", out_depth, '0);
      end else begin
        want_px = expected_px.pop_front();
        check_field("out_depth", out_depth, want_px.depth);
        check_field("box_top", DEPTH_W'(box_top), DEPTH_W'(want_px.top));
        check_field("box_bottom", DEPTH_W'(box_bottom), DEPTH_W'(want_px.bottom));
        check_field("box_left", DEPTH_W'(box_left), DEPTH_W'(want_px.left));
        check_field("box_right", DEPTH_W'(box_right), DEPTH_W'(want_px.right));
        check_field("box_found", DEPTH_W'(box_found), DEPTH_W'(want_px.found));
        check_field("frame_end", DEPTH_W'(frame_end), DEPTH_W'(want_px.last));
      end
    end
  end

  // Watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    int i, n;
    shadow_width = FRAME_WIDTH_RST;
    shadow_height = FRAME_HEIGHT_RST;
    shadow_margin = MARGIN_RST;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Composite before any detect pass: no box, background depth
    set_idling(0);
    queue_pixel(fixed_pixel(OP_COMPOSITE, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF,
                            32'hFFFF_FFFF, 32'h0000_0000));
    queue_pixel(fixed_pixel(OP_COMPOSITE, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00,
                            32'h0000_0000, 32'hFFFF_FFFF));
    wait_idle();

    // Shrink the frame while the composite position is mid-row
    write_reg(CFG_FRAME_WIDTH, 11'd3);
    write_reg(CFG_FRAME_HEIGHT, 11'd2);
    write_reg(CFG_MARGIN, 11'd0);
    queue_pixel(fixed_pixel(OP_DETECT, 8'h5A, 8'h5A, 8'h5A, 8'h5A, 8'h5A, 8'h5A,
                            32'h0, 32'h0));
    queue_pixel(fixed_pixel(OP_DETECT, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF,
                            32'hFFFF_FFFF, 32'hFFFF_FFFF));
    queue_pixel(fixed_pixel(OP_DETECT, 8'h12, 8'h34, 8'h56, 8'h12, 8'h35, 8'h57,
                            32'h0, 32'h0));
    queue_pixel(fixed_pixel(OP_DETECT, 8'h12, 8'h34, 8'h56, 8'h13, 8'h34, 8'h57,
                            32'h0, 32'h0));
    queue_pixel(fixed_pixel(OP_DETECT, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00,
                            32'h0, 32'h0));
    queue_pixel(fixed_pixel(OP_DETECT, 8'h12, 8'h34, 8'h56, 8'h13, 8'h35, 8'h56,
                            32'h0, 32'h0));
    for (i = 0; i < 6; i++)
      queue_pixel(fixed_pixel(OP_COMPOSITE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                              8'h00, 32'hA5A5_A5A5 ^ i, 32'h5A5A_5A5A ^ i));
    wait_idle();

    // Widest margin reaches past the border without wrapping
    write_reg(CFG_MARGIN, 11'd63);
    for (i = 0; i < 6; i++)
      queue_pixel(fixed_pixel(OP_COMPOSITE, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                              8'hFF, 32'hFFFF_FFFF, 32'h0));
    wait_idle();

    // Zero sizes act as a one-pixel frame
    write_reg(CFG_FRAME_WIDTH, 11'd0);
    write_reg(CFG_FRAME_HEIGHT, 11'd0);
    queue_pixel(fixed_pixel(OP_DETECT, 8'h01, 8'h02, 8'h03, 8'h80, 8'h40, 8'h20,
                            32'h0, 32'h0));
    queue_pixel(fixed_pixel(OP_COMPOSITE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                            8'h00, 32'h8000_0001, 32'h7FFF_FFFE));
    queue_pixel(fixed_pixel(OP_DETECT, 8'h01, 8'h02, 8'h03, 8'h01, 8'h40, 8'h20,
                            32'h0, 32'h0));
    queue_pixel(fixed_pixel(OP_COMPOSITE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                            8'h00, 32'h8000_0001, 32'h7FFF_FFFE));
    wait_idle();

    // Oversize frames saturate to the maximum
    set_idling(3);
    write_reg(CFG_FRAME_WIDTH, 11'd2047);
    write_reg(CFG_FRAME_HEIGHT, 11'd1024);
    for (i = 0; i < 40; i++) queue_pixel(make_pixel(OP_DETECT, $urandom_range(99) < 30));
    for (i = 0; i < 40; i++) queue_pixel(make_pixel(OP_COMPOSITE, 1'b0));
    wait_idle();
    write_reg(CFG_FRAME_WIDTH, 11'd1024);
    write_reg(CFG_FRAME_HEIGHT, 11'd2047);
    write_reg(CFG_MARGIN, 11'd0);
    for (i = 0; i < 30; i++)
      queue_pixel(make_pixel(op_t'($urandom_range(1)), 1'($urandom_range(1))));
    wait_idle();

    // Random phases: small frames, new frame size each time, sometimes a new margin, some noise between
    while (random_count < RANDOM_PIXELS) begin
      set_idling(phase_no);
      case ($urandom_range(9))
        0:       write_reg(CFG_FRAME_WIDTH, 11'd1);
        1:       write_reg(CFG_FRAME_WIDTH, 11'd0);
        default: write_reg(CFG_FRAME_WIDTH, CFG_W'($urandom_range(2, 8)));
      endcase
      case ($urandom_range(9))
        0:       write_reg(CFG_FRAME_HEIGHT, 11'd1);
        1:       write_reg(CFG_FRAME_HEIGHT, 11'd0);
        default: write_reg(CFG_FRAME_HEIGHT, CFG_W'($urandom_range(2, 6)));
      endcase
      if ($urandom_range(1)) begin
        case ($urandom_range(3))
          0:       write_reg(CFG_MARGIN, 11'd0);
          1:       write_reg(CFG_MARGIN, 11'd63);
          default: write_reg(CFG_MARGIN, CFG_W'($urandom_range(1, 5)));
        endcase
      end
      n = $urandom_range(1, 3);
      for (i = 0; i < n; i++) queue_frame_pair();
      if ($urandom_range(4) == 0) begin
        n = $urandom_range(1, 5);
        for (i = 0; i < n; i++) begin
          queue_pixel(make_pixel(op_t'($urandom_range(1)), 1'($urandom_range(1))));
          random_count++;
        end
      end
      wait_idle();
      phase_no++;
    end

    repeat (LATENCY + 4) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/fbdc_pkg.sv
hdl/fbdc_raster.sv
hdl/fbdc_box.sv
hdl/foreground_box_depth_composite_top.sv
dv/foreground_box_depth_composite_top_tb.sv
